// ===== rtl/mpr_pkg.sv =====
// mpr_pkg: shared types, widths, codes and reset values for the motor PWM ramp controller.
// Has no dependencies. All rtl/ files of the block import it.
package mpr_pkg;

  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned MAX_W      = 15;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned TPS_W      = 16;
  localparam int unsigned TARGET_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W     = PERIOD_W + MAX_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W);

  localparam int STEP_SIZE = 10;

  localparam logic [MAX_W-1:0]    MAX_LEVEL_RST      = MAX_W'(1000);
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST     = PERIOD_W'(1000);
  localparam logic [TPS_W-1:0]    TICKS_PER_STEP_RST = TPS_W'(50);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RAMP = 2'd1,
    OP_SET  = 2'd2,
    OP_ADD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [LEVEL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] drive_level;
    logic [PERIOD_W-1:0]       compare_value;
    dir_t                      direction;
    logic                      ramp_active;
  } out_word_t;

endpackage

// ===== rtl/motor_pwm_ramp_controller.sv =====
// motor_pwm_ramp_controller: top level, sequencer, config registers and result register.
// Depends on mpr_pkg, mpr_ramp and mpr_div.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------
//   in_     | input     | in_valid / in_ready   | in_word_t  (operation, value)
//   out_    | output    | out_valid / out_ready | out_word_t (level, compare, dir, ramp)
//   cfg_    | input     | cfg_we, no wait       | cfg_index, cfg_wdata
//
// One word passes from acceptance to out_valid through update, magnitude, multiply,
// the serial divider steps plus the done cycle, and the result load. in_ready rises
// together with out_valid, when the result is loaded.
// Reset (rst_n low, synchronous) clears the level, ramp state, sequencer and restores
// the config defaults. A result stalled on out_ready holds the block in its load state.
module motor_pwm_ramp_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mpr_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mpr_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mpr_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_MAG  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [MAX_W-1:0]    max_level_r,  max_level_nxt;
  logic [PERIOD_W-1:0] pwm_period_r, pwm_period_nxt;
  logic [TPS_W-1:0]    tps_r,        tps_nxt;

  in_word_t  item_r,      item_nxt;
  logic [MAX_W-1:0] headroom_r, headroom_nxt;
  out_word_t out_r,       out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic signed [LEVEL_W-1:0] level;
  logic                      ramp_active;
  logic                      in_accept;
  logic                      apply;
  logic                      div_start;
  logic                      div_done;
  logic [PERIOD_W-1:0]       quotient;
  logic [LEVEL_W-1:0]        abs_level;
  logic [MAX_W-1:0]          mag;
  logic [PROD_W-1:0]         product;
  logic                      out_load;

  mpr_ramp u_ramp (
    .clk            (clk),
    .rst_n          (rst_n),
    .apply          (apply),
    .item           (item_r),
    .max_level      (max_level_r),
    .ticks_per_step (tps_r),
    .level          (level),
    .ramp_active    (ramp_active)
  );

  mpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (max_level_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign apply     = (state_r == S_UPD);
  assign div_start = (state_r == S_MUL);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // magnitude of the level, clamped to max_level so a level left above a lowered
  // limit drives a zero compare
  always_comb begin
    abs_level = level[LEVEL_W-1] ? (~level + 1'b1) : level;
    if (abs_level > {1'b0, max_level_r}) begin
      mag = max_level_r;
    end else begin
      mag = abs_level[MAX_W-1:0];
    end
    headroom_nxt = (state_r == S_MAG) ? (max_level_r - mag) : headroom_r;
    product      = {{(PROD_W-PERIOD_W){1'b0}}, pwm_period_r}
                 * {{(PROD_W-MAX_W){1'b0}}, headroom_r};
  end

  // config writes
  always_comb begin
    max_level_nxt  = max_level_r;
    pwm_period_nxt = pwm_period_r;
    tps_nxt        = tps_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LEVEL:      max_level_nxt  = cfg_wdata[MAX_W-1:0];
        CFG_PWM_PERIOD:     pwm_period_nxt = cfg_wdata[PERIOD_W-1:0];
        CFG_TICKS_PER_STEP: tps_nxt        = cfg_wdata[TPS_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    item_nxt  = in_accept ? in_data : item_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_MAG;
      S_MAG:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
    endcase
  end

  // result register; hold it until the sink takes it
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_nxt.drive_level       = level;
      // zero limit: the full period stands as the compare value
      out_nxt.compare_value     = (max_level_r == '0) ? pwm_period_r : quotient;
      out_nxt.ramp_active       = ramp_active;
      if (level[LEVEL_W-1]) begin
        out_nxt.direction = DIR_REV;
      end else if (level != '0) begin
        out_nxt.direction = DIR_FWD;
      end else begin
        out_nxt.direction = DIR_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    headroom_r <= headroom_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      max_level_r  <= MAX_LEVEL_RST;
      pwm_period_r <= PWM_PERIOD_RST;
      tps_r        <= TICKS_PER_STEP_RST;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      max_level_r  <= max_level_nxt;
      pwm_period_r <= pwm_period_nxt;
      tps_r        <= tps_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/mpr_ramp.sv =====
// mpr_ramp: drive level register, soft-start ramp counters and saturation.
// Depends on mpr_pkg.
module mpr_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              apply,
  input  mpr_pkg::in_word_t                 item,
  input  logic [mpr_pkg::MAX_W-1:0]         max_level,
  input  logic [mpr_pkg::TPS_W-1:0]         ticks_per_step,
  output logic signed [mpr_pkg::LEVEL_W-1:0] level,
  output logic                              ramp_active
);
  import mpr_pkg::*;

  localparam int unsigned SUM_W = LEVEL_W + 2;
  localparam logic signed [SUM_W-1:0] STEP_V = SUM_W'(STEP_SIZE);
  localparam logic signed [TARGET_W-1:0] COUNT_ONE = signed'(TARGET_W'(1));

  // clamp a wide signed sum to plus or minus the limit
  function automatic logic signed [LEVEL_W-1:0] sat(input logic signed [SUM_W-1:0] v,
                                                    input logic [MAX_W-1:0] lim);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = signed'({{(SUM_W-MAX_W){1'b0}}, lim});
    lo = -hi;
    r  = v;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end
    return r[LEVEL_W-1:0];
  endfunction

  logic signed [LEVEL_W-1:0]  level_r,  level_nxt;
  logic signed [TARGET_W-1:0] target_r, target_nxt;
  logic signed [TARGET_W-1:0] count_r,  count_nxt;
  logic [TPS_W-1:0]           tick_r,   tick_nxt;
  logic                       en_r,     en_nxt;

  logic signed [SUM_W-1:0] level_ext;
  logic signed [SUM_W-1:0] value_ext;
  logic [TPS_W-1:0]        tick_inc;

  always_comb begin
    level_ext  = signed'({{(SUM_W-LEVEL_W){level_r[LEVEL_W-1]}}, level_r});
    value_ext  = signed'({{(SUM_W-LEVEL_W){item.value[LEVEL_W-1]}}, item.value});
    tick_inc   = (tick_r != '1) ? tick_r + 1'b1 : tick_r;
    level_nxt  = level_r;
    target_nxt = target_r;
    count_nxt  = count_r;
    tick_nxt   = tick_r;
    en_nxt     = en_r;
    if (apply) begin
      unique case (item.operation)
        OP_TICK: begin
          if (en_r) begin
            if (tick_inc < ticks_per_step) begin
              tick_nxt = tick_inc;
            end else begin
              tick_nxt = '0;
              if (count_r < target_r) begin
                count_nxt = count_r + COUNT_ONE;
                level_nxt = sat(level_ext + STEP_V, max_level);
              end else if (count_r > target_r) begin
                count_nxt = count_r - COUNT_ONE;
                level_nxt = sat(level_ext - STEP_V, max_level);
              end else begin
                en_nxt = 1'b0;
              end
            end
          end
        end
        OP_RAMP: begin
          target_nxt = signed'(item.value[TARGET_W-1:0]);
          en_nxt     = 1'b1;
        end
        OP_SET:  level_nxt = sat(value_ext, max_level);
        OP_ADD:  level_nxt = sat(level_ext + value_ext, max_level);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      count_r  <= '0;
      tick_r   <= '0;
      en_r     <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      count_r  <= count_nxt;
      tick_r   <= tick_nxt;
      en_r     <= en_nxt;
    end
  end

  assign level       = level_r;
  assign ramp_active = en_r;

endmodule

// ===== rtl/mpr_div.sv =====
// mpr_div: restoring serial divider, one quotient bit per cycle.
// Depends on mpr_pkg.
module mpr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mpr_pkg::PROD_W-1:0]     dividend,
  input  logic [mpr_pkg::MAX_W-1:0]      divisor,
  output logic                           done,
  output logic [mpr_pkg::PERIOD_W-1:0]   quotient
);
  import mpr_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(PROD_W - 1);

  logic [MAX_W-1:0]     rem_r,  rem_nxt;
  logic [PROD_W-1:0]    dq_r,   dq_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [MAX_W:0] trial;
  logic [MAX_W:0] diff;
  logic           fits;

  always_comb begin
    trial    = {rem_r, dq_r[PROD_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dq_nxt   = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_nxt = fits ? diff[MAX_W-1:0] : trial[MAX_W-1:0];
      dq_nxt  = {dq_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[PERIOD_W-1:0];

endmodule

// ===== rtl/mpr_checker.sv =====
// mpr_checker: port-level assertions for motor_pwm_ramp_controller, bound to the top level.
// Depends on mpr_pkg.
module mpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mpr_pkg::out_word_t out_data
);
  import mpr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a word was accepted");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_dir_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.direction == DIR_STOP) == (out_data.drive_level == 0)))
    else $error("stop direction disagrees with zero level");

  a_dir_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.direction == DIR_REV) == (out_data.drive_level < 0)))
    else $error("backward direction disagrees with level sign");

endmodule

bind motor_pwm_ramp_controller mpr_checker u_mpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/motor_pwm_ramp_controller_tb.sv =====
// motor_pwm_ramp_controller_tb: self-checking bench for the motor PWM ramp controller.
// Drives command words with bursty valid/ready timing, predicts every result word and
// checks it field by field. Depends on mpr_pkg and motor_pwm_ramp_controller.
module motor_pwm_ramp_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpr_pkg::*;

  localparam int STALL_LIMIT      = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES     = 40;    // extra drain time once the block has nothing in flight
  localparam int RANDOM_PHASES    = 8;
  localparam int RANDOM_PER_PHASE = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_pwm_ramp_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Drive-level predictor: shadow config plus its own copy of the ramp state.
  // ---------------------------------------------------------------------------
  int unsigned max_lvl_cfg = 32'(MAX_LEVEL_RST);
  int unsigned period_cfg  = 32'(PWM_PERIOD_RST);
  int unsigned ticks_cfg   = 32'(TICKS_PER_STEP_RST);

  int          drive_lvl  = 0;
  int          ramp_goal  = 0;   // signed 8-bit target, sign extended
  int          ramp_pos   = 0;   // signed 8-bit ramp counter
  int unsigned step_ticks = 0;
  bit          ramp_on    = 1'b0;

  in_word_t  queued_words[$];    // command words not yet offered to the block
  out_word_t pending_status[$];  // predicted result words, oldest first
  int        mismatch_count = 0;

  // Clamp a new level to plus or minus the full-scale level in force now.
  function automatic void store_level(int lvl);
    int lim;
    lim = int'(max_lvl_cfg);
    if (lvl > lim) lvl = lim;
    if (lvl < -lim) lvl = -lim;
    drive_lvl = lvl;
  endfunction

  function automatic out_word_t next_drive_status(in_word_t w);
    int               val;
    logic signed [7:0] goal8;
    int unsigned      mag;
    longint           cmp;
    out_word_t        r;
    val = int'(w.value);
    case (w.operation)
      OP_TICK: begin
        // A tick with the ramp off changes nothing, not even the tick count.
        if (ramp_on) begin
          if (step_ticks < 32'hFFFF) step_ticks++;
          if (step_ticks >= ticks_cfg) begin
            if (ramp_pos < ramp_goal) begin
              ramp_pos++;
              store_level(drive_lvl + STEP_SIZE);
            end else if (ramp_pos > ramp_goal) begin
              ramp_pos--;
              store_level(drive_lvl - STEP_SIZE);
            end else begin
              ramp_on = 1'b0;
            end
            step_ticks = 0;
          end
        end
      end
      OP_RAMP: begin
        // Keep the counters: a restarted ramp continues from where it is.
        goal8     = w.value[7:0];
        ramp_goal = int'(goal8);
        ramp_on   = 1'b1;
      end
      OP_SET: store_level(val);
      default: store_level(drive_lvl + val);
    endcase

    // A level left above a lowered full scale counts as full scale.
    mag = (drive_lvl < 0) ? -drive_lvl : drive_lvl;
    if (mag > max_lvl_cfg) mag = max_lvl_cfg;
    if (max_lvl_cfg == 0) cmp = longint'(period_cfg);
    else cmp = (longint'(period_cfg) * longint'(max_lvl_cfg - mag)) / max_lvl_cfg;

    r.drive_level   = drive_lvl[15:0];
    r.compare_value = cmp[15:0];
    r.direction     = (drive_lvl < 0) ? DIR_REV : ((drive_lvl > 0) ? DIR_FWD : DIR_STOP);
    r.ramp_active   = ramp_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Sample acceptance at the rising edge and predict right there,
  // so the config shadow matches what the block sees for that word.
  // ---------------------------------------------------------------------------
  logic word_taken = 1'b0;

  always @(posedge clk) begin : accept_side
    word_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      pending_status.push_back(next_drive_status(in_data));
    end
  end

  // Driver: offer words in bursts of random length with random gaps between.
  // Hold valid and data steady until the word is taken.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_words.size() != 0) begin
        in_data  <= queued_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          // Start a new burst; about a third of bursts follow with no gap at all.
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. The receiver switches between stall patterns at random
  // intervals: always ready, mostly ready, toggling, and long stalls.
  // ---------------------------------------------------------------------------
  int ready_mode      = 0;
  int ready_mode_left = 0;
  int stall_left      = 0;

  always @(negedge clk) begin : receiver
    if (ready_mode_left == 0) begin
      ready_mode      = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(50, 400);
    end else begin
      ready_mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= !out_ready;
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
        end
      end
    endcase
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result word with no prediction waiting: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (out_data.drive_level !== want.drive_level) begin
          $error("drive_level: expected %0d, got %0d", want.drive_level, out_data.drive_level);
          mismatch_count++;
        end
        if (out_data.compare_value !== want.compare_value) begin
          $error("compare_value: expected %0d, got %0d",
                 want.compare_value, out_data.compare_value);
          mismatch_count++;
        end
        if (out_data.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, out_data.direction);
          mismatch_count++;
        end
        if (out_data.ramp_active !== want.ramp_active) begin
          $error("ramp_active: expected %0d, got %0d", want.ramp_active, out_data.ramp_active);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_word_t mk_word(op_t op, logic [15:0] v);
    in_word_t w;
    w.operation = op;
    w.value     = v;
    return w;
  endfunction

  // Wait until the block has nothing in flight, then let the latency run out.
  task automatic settle_block();
    do @(posedge clk);
    while (queued_words.size() != 0 || in_valid || pending_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one config register and update the predictor's shadow copy.
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_LEVEL:      max_lvl_cfg = 32'(data & 16'h7FFF);
      CFG_PWM_PERIOD:     period_cfg  = 32'(data);
      CFG_TICKS_PER_STEP: ticks_cfg   = 32'(data);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed words, then random phases with new config.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    static int unsigned tab_max[RANDOM_PHASES]    = '{1000, 32767, 1, 32767, 0, 250, 0, 1000};
    static int unsigned tab_period[RANDOM_PHASES] = '{1000, 65535, 1, 0, 777, 12345, 0, 1000};
    static int unsigned tab_ticks[RANDOM_PHASES]  = '{50, 0, 1, 65535, 2, 3, 0, 1};
    int unsigned pm, pp, pt;
    int          pick, v;
    logic [7:0]  goal_lo;
    in_word_t    w;

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, full scale 1000, period 1000: step the ramp on every tick.
    set_register(CFG_TICKS_PER_STEP, 16'd0);
    queued_words.push_back(mk_word(OP_TICK, 16'h5A5A));  // tick while the ramp is off
    queued_words.push_back(mk_word(OP_SET, 16'h7FFF));   // saturate high
    queued_words.push_back(mk_word(OP_SET, 16'h8000));   // saturate low
    queued_words.push_back(mk_word(OP_ADD, 16'h8000));   // add overflow, negative
    queued_words.push_back(mk_word(OP_ADD, 16'h7FFF));   // add overflow, positive
    queued_words.push_back(mk_word(OP_SET, 16'h0000));   // stop
    queued_words.push_back(mk_word(OP_RAMP, 16'hFF02));  // target 2, upper bits ignored
    repeat (3) queued_words.push_back(mk_word(OP_TICK, 16'hFFFF));
    queued_words.push_back(mk_word(OP_RAMP, 16'h00FE));  // restart toward -2 from 2
    repeat (5) queued_words.push_back(mk_word(OP_TICK, 16'h0000));
    queued_words.push_back(mk_word(OP_SET, 16'h0001));
    queued_words.push_back(mk_word(OP_SET, 16'(-999)));

    // Lower full scale under a large stored level: compare drops to zero.
    settle_block();
    set_register(CFG_MAX_LEVEL, 16'd100);
    set_register(CFG_PWM_PERIOD, 16'hFFFF);
    queued_words.push_back(mk_word(OP_TICK, 16'h1234));
    queued_words.push_back(mk_word(OP_ADD, 16'h0001));
    queued_words.push_back(mk_word(OP_SET, 16'd50));

    // Full scale zero, written with the unused top bit set: every level is zero.
    settle_block();
    set_register(CFG_MAX_LEVEL, 16'h8000);
    set_register(CFG_PWM_PERIOD, 16'd777);
    queued_words.push_back(mk_word(OP_SET, 16'd123));
    queued_words.push_back(mk_word(OP_RAMP, 16'h0001));
    repeat (2) queued_words.push_back(mk_word(OP_TICK, 16'hA5A5));

    // Random phases. Each one waits for the block to drain, which also makes
    // the sender pause until every predicted word has come back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      pm = tab_max[p];
      pp = tab_period[p];
      pt = tab_ticks[p];
      if (p == RANDOM_PHASES - 2) begin
        pm = $urandom_range(1, 32767);
        pp = $urandom_range(0, 65535);
        pt = $urandom_range(0, 6);
      end
      set_register(CFG_MAX_LEVEL, {1'($urandom_range(0, 1)), pm[14:0]});
      set_register(CFG_PWM_PERIOD, pp[15:0]);
      set_register(CFG_TICKS_PER_STEP, pt[15:0]);

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        v    = $urandom_range(0, 65535);
        if (pick < 55) begin
          w = mk_word(OP_TICK, v[15:0]);
        end else if (pick < 67) begin
          // Mostly near targets so ramps finish; now and then any target.
          if ($urandom_range(0, 4) != 0) begin
            goal_lo = 8'($urandom_range(0, 30) - 15);
            v[7:0]  = goal_lo;
          end
          w = mk_word(OP_RAMP, v[15:0]);
        end else if (pick < 83) begin
          if ($urandom_range(0, 3) != 0) v = int'($urandom_range(0, 2 * pm)) - int'(pm);
          w = mk_word(OP_SET, v[15:0]);
        end else begin
          if ($urandom_range(0, 4) != 0) v = int'($urandom_range(0, 80)) - 40;
          w = mk_word(OP_ADD, v[15:0]);
        end
        queued_words.push_back(w);
      end
    end

    // Drain the last words and give the block time for anything unexpected.
    settle_block();
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
